// ===== hdl/ssi_pkg.sv =====
`default_nettype none
package ssi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int TOLW = 32;
  localparam logic [TOLW-1:0] TOL_RESET = 32'd4295;

  // coordinate difference, squared length, root and divider widths
  localparam int DW = COORD_WIDTH + 1;
  localparam int AW = 2 * COORD_WIDTH + 2;
  localparam int PW = AW + 1;
  localparam int PRW = 2 * AW;
  localparam int QW = PRW + 2;
  localparam int SQW = 4 * COORD_WIDTH;
  localparam int RTW = 2 * COORD_WIDTH;
  localparam int RMW = RTW + 2;
  localparam int NW = AW + 2;
  localparam int NMW = AW + 1;
  localparam int NL = NMW / 2 + 1;
  localparam int MW = NMW + DW;
  localparam int DVW = MW + 2;
  localparam int QTW = COORD_WIDTH + 4;
  localparam int DRW = AW + 1;
  localparam int LANES = 6;

  localparam int FRONT_LAT = 7;
  localparam int COORD_LAT = QTW + 4;
  localparam int LATENCY = FRONT_LAT + RTW + COORD_LAT;

  localparam logic [2:0] ST_DEGEN   = 3'd0;
  localparam logic [2:0] ST_OFF     = 3'd1;
  localparam logic [2:0] ST_MISS    = 3'd2;
  localparam logic [2:0] ST_TANGENT = 3'd3;
  localparam logic [2:0] ST_TWO     = 3'd4;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] centre_x;
    logic signed [COORD_WIDTH-1:0] centre_y;
    logic signed [COORD_WIDTH-1:0] centre_z;
    logic [COORD_WIDTH-2:0]        radius;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic [1:0]                    hit_count;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
  } out_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic signed [COORD_WIDTH-1:0] sz;
    logic signed [DW-1:0]          dx;
    logic signed [DW-1:0]          dy;
    logic signed [DW-1:0]          dz;
    logic [AW-1:0]                 a;
    logic [AW-1:0]                 p;
  } geo_t;

  typedef struct packed {
    logic           neg;
    logic [DRW-1:0] rem;
    logic [QTW-1:0] low;
  } lane_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic signed [COORD_WIDTH-1:0] sz;
    logic [AW-1:0]                 a;
    lane_t [LANES-1:0]             lane;
  } dv_t;

endpackage
`default_nettype wire

// ===== hdl/ssi_front.sv =====
`default_nettype none
module ssi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  ssi_pkg::in_t               in_data,
  input  logic [ssi_pkg::TOLW-1:0]   tol,
  output logic                       geo_valid,
  output ssi_pkg::geo_t              geo,
  output logic [ssi_pkg::SQW-1:0]    geo_q
);

  localparam int H = ssi_pkg::AW / 2;
  localparam int DW = ssi_pkg::DW;
  localparam int AW = ssi_pkg::AW;
  localparam int PW = ssi_pkg::PW;
  localparam int PRW = ssi_pkg::PRW;
  localparam int QW = ssi_pkg::QW;
  localparam int CW = ssi_pkg::COORD_WIDTH;

  logic [ssi_pkg::FRONT_LAT-1:0] v_r;
  ssi_pkg::geo_t g_r [ssi_pkg::FRONT_LAT];
  ssi_pkg::geo_t g1_nxt, g3_nxt, g7_nxt;

  logic signed [DW-1:0]   w1_r [3];
  logic [CW-2:0]          r1_r;
  logic signed [DW-1:0]   d1 [3];
  logic signed [2*DW-1:0] dd2_r [3];
  logic signed [2*DW-1:0] dw2_r [3];
  logic signed [2*DW-1:0] ww2_r [3];
  logic [2*CW-3:0]        rr2_r;
  logic [AW-1:0]          a3_nxt;
  logic signed [PW-1:0]   p3_nxt, p3_r, k3_r;
  logic [AW-1:0]          pu, kmag;
  logic                   degen4_r, off4_r, kneg4_r;
  logic                   degen5_r, off5_r, kneg5_r;
  logic                   degen6_r, off6_r;
  logic [2*H-1:0]         pll4_r, plh4_r, phh4_r;
  logic [2*H-1:0]         akll4_r, aklh4_r, akhl4_r, akhh4_r;
  logic [PRW-1:0]         p2_5_r, ak5_r;
  logic signed [QW-1:0]   q6_r;
  logic [2:0]             st7_nxt;
  logic [ssi_pkg::SQW-1:0] q7_r;

  always_comb begin
    g1_nxt = '0;
    g1_nxt.status = ssi_pkg::ST_DEGEN;
    g1_nxt.sx = in_data.start_x;
    g1_nxt.sy = in_data.start_y;
    g1_nxt.sz = in_data.start_z;
    g1_nxt.dx = DW'(in_data.end_x) - DW'(in_data.start_x);
    g1_nxt.dy = DW'(in_data.end_y) - DW'(in_data.start_y);
    g1_nxt.dz = DW'(in_data.end_z) - DW'(in_data.start_z);
  end

  assign d1[0] = g_r[0].dx;
  assign d1[1] = g_r[0].dy;
  assign d1[2] = g_r[0].dz;

  // squared length, minus the projection and the offset term
  always_comb begin
    a3_nxt = AW'($unsigned(dd2_r[0])) + AW'($unsigned(dd2_r[1]))
           + AW'($unsigned(dd2_r[2]));
    p3_nxt = -(PW'(dw2_r[0]) + PW'(dw2_r[1]) + PW'(dw2_r[2]));
  end

  always_comb begin
    g3_nxt = g_r[1];
    g3_nxt.a = a3_nxt;
    g3_nxt.p = p3_nxt[AW-1:0];
  end

  assign pu = p3_r[AW-1:0];
  assign kmag = k3_r[PW-1] ? AW'(-k3_r) : AW'(k3_r);

  always_comb begin
    priority if (degen6_r) begin
      st7_nxt = ssi_pkg::ST_DEGEN;
    end else if (off6_r) begin
      st7_nxt = ssi_pkg::ST_OFF;
    end else if (q6_r[QW-1]) begin
      st7_nxt = ssi_pkg::ST_MISS;
    end else if ($unsigned(q6_r) < QW'({tol, 30'd0})) begin
      st7_nxt = ssi_pkg::ST_TANGENT;
    end else begin
      st7_nxt = ssi_pkg::ST_TWO;
    end
  end

  always_comb begin
    g7_nxt = g_r[5];
    g7_nxt.status = st7_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[ssi_pkg::FRONT_LAT-2:0], in_valid};
    end

    // stage 1: differences
    g_r[0] <= g1_nxt;
    w1_r[0] <= DW'(in_data.start_x) - DW'(in_data.centre_x);
    w1_r[1] <= DW'(in_data.start_y) - DW'(in_data.centre_y);
    w1_r[2] <= DW'(in_data.start_z) - DW'(in_data.centre_z);
    r1_r <= in_data.radius;

    // stage 2: products
    g_r[1] <= g_r[0];
    for (int i = 0; i < 3; i++) begin
      dd2_r[i] <= d1[i] * d1[i];
      dw2_r[i] <= d1[i] * w1_r[i];
      ww2_r[i] <= w1_r[i] * w1_r[i];
    end
    rr2_r <= r1_r * r1_r;

    // stage 3: dot product sums
    g_r[2] <= g3_nxt;
    p3_r <= p3_nxt;
    k3_r <= PW'(ww2_r[0]) + PW'(ww2_r[1]) + PW'(ww2_r[2]) - PW'(rr2_r);

    // stage 4: partial products, early classification
    g_r[3] <= g_r[2];
    degen4_r <= (g_r[2].a == '0) || (g_r[2].a < AW'(tol));
    off4_r <= p3_r[PW-1] || (pu > g_r[2].a);
    kneg4_r <= k3_r[PW-1];
    pll4_r <= pu[H-1:0] * pu[H-1:0];
    plh4_r <= pu[H-1:0] * pu[AW-1:H];
    phh4_r <= pu[AW-1:H] * pu[AW-1:H];
    akll4_r <= g_r[2].a[H-1:0] * kmag[H-1:0];
    aklh4_r <= g_r[2].a[H-1:0] * kmag[AW-1:H];
    akhl4_r <= g_r[2].a[AW-1:H] * kmag[H-1:0];
    akhh4_r <= g_r[2].a[AW-1:H] * kmag[AW-1:H];

    // stage 5: assemble wide products
    g_r[4] <= g_r[3];
    degen5_r <= degen4_r;
    off5_r <= off4_r;
    kneg5_r <= kneg4_r;
    p2_5_r <= (PRW'(phh4_r) << (2*H)) + (PRW'(plh4_r) << (H+1)) + PRW'(pll4_r);
    ak5_r <= (PRW'(akhh4_r) << (2*H)) + ((PRW'(aklh4_r) + PRW'(akhl4_r)) << H)
           + PRW'(akll4_r);

    // stage 6: quarter discriminant
    g_r[5] <= g_r[4];
    degen6_r <= degen5_r;
    off6_r <= off5_r;
    q6_r <= kneg5_r ? (QW'(p2_5_r) + QW'(ak5_r)) : (QW'(p2_5_r) - QW'(ak5_r));

    // stage 7: status
    g_r[6] <= g7_nxt;
    q7_r <= q6_r[ssi_pkg::SQW-1:0];
  end

  assign geo_valid = v_r[ssi_pkg::FRONT_LAT-1];
  assign geo = g_r[ssi_pkg::FRONT_LAT-1];
  assign geo_q = q7_r;

endmodule
`default_nettype wire

// ===== hdl/ssi_sqrt.sv =====
`default_nettype none
module ssi_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  ssi_pkg::geo_t            in_geo,
  input  logic [ssi_pkg::SQW-1:0]  in_q,
  output logic                     out_valid,
  output ssi_pkg::geo_t            out_geo,
  output logic [ssi_pkg::RTW-1:0]  out_root
);

  localparam int RTW = ssi_pkg::RTW;
  localparam int RMW = ssi_pkg::RMW;
  localparam int SQW = ssi_pkg::SQW;

  logic          v_r    [RTW];
  ssi_pkg::geo_t g_r    [RTW];
  logic [RMW-1:0] rem_r [RTW];
  logic [RTW-1:0] root_r [RTW];
  logic [SQW-1:0] q_r   [RTW];

  // one root bit per stage, two radicand bits consumed each time
  for (genvar i = 0; i < RTW; i++) begin : g_stage
    logic           vi;
    ssi_pkg::geo_t  gi;
    logic [RMW-1:0] ri;
    logic [RTW-1:0] ti;
    logic [SQW-1:0] qi;
    logic [RMW:0]   cur, trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign gi = in_geo;
      assign ri = '0;
      assign ti = '0;
      assign qi = in_q;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign gi = g_r[i-1];
      assign ri = rem_r[i-1];
      assign ti = root_r[i-1];
      assign qi = q_r[i-1];
    end

    assign cur = {ri[RMW-2:0], qi[SQW-1-2*i -: 2]};
    assign trial = {1'b0, ti, 2'b01};
    assign ge = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vi;
      end
      g_r[i] <= gi;
      q_r[i] <= qi;
      rem_r[i] <= ge ? RMW'(cur - trial) : RMW'(cur);
      root_r[i] <= {ti[RTW-2:0], ge};
    end
  end

  assign out_valid = v_r[RTW-1];
  assign out_geo = g_r[RTW-1];
  assign out_root = root_r[RTW-1];

endmodule
`default_nettype wire

// ===== hdl/ssi_coord.sv =====
`default_nettype none
module ssi_coord (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  ssi_pkg::geo_t            in_geo,
  input  logic [ssi_pkg::RTW-1:0]  in_root,
  output logic                     out_valid,
  output ssi_pkg::out_t            out_data
);

  localparam int CW = ssi_pkg::COORD_WIDTH;
  localparam int DW = ssi_pkg::DW;
  localparam int NW = ssi_pkg::NW;
  localparam int NMW = ssi_pkg::NMW;
  localparam int NL = ssi_pkg::NL;
  localparam int MW = ssi_pkg::MW;
  localparam int DVW = ssi_pkg::DVW;
  localparam int QTW = ssi_pkg::QTW;
  localparam int DRW = ssi_pkg::DRW;
  localparam int LANES = ssi_pkg::LANES;
  localparam int VW = QTW + 2;
  localparam logic signed [VW-1:0] VMAX = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // stage a: numerators p+s and p-s
  logic                 va_r;
  ssi_pkg::geo_t        ga_r;
  logic [NMW-1:0]       n1_r, n2_r;
  logic                 n2neg_r;
  logic [ssi_pkg::RTW-1:0] s_eff;
  logic signed [NW-1:0] n2_nxt;

  // stage b: partial products per lane
  logic                 vb_r;
  ssi_pkg::geo_t        gb_r;
  logic [NL+DW-1:0]     lo_r [LANES];
  logic [NMW-NL+DW-1:0] hi_r [LANES];
  logic                 negb_r [LANES];
  logic signed [DW-1:0] dsel [3];

  // stage c: dividend
  logic                 vc_r;
  ssi_pkg::dv_t         dc_nxt, dc_r;

  // long division stages
  logic                 vd_r [QTW];
  ssi_pkg::dv_t         dd_r [QTW];

  logic signed [CW-1:0] coord [LANES];
  ssi_pkg::out_t        out_nxt, out_r;
  logic                 out_valid_r;

  assign s_eff = (in_geo.status == ssi_pkg::ST_TANGENT) ? '0 : in_root;
  assign n2_nxt = NW'(in_geo.p) - NW'(s_eff);

  assign dsel[0] = ga_r.dx;
  assign dsel[1] = ga_r.dy;
  assign dsel[2] = ga_r.dz;

  always_comb begin
    logic [MW-1:0]  mag;
    logic [DVW-1:0] dvd;
    dc_nxt = '0;
    dc_nxt.status = gb_r.status;
    dc_nxt.sx = gb_r.sx;
    dc_nxt.sy = gb_r.sy;
    dc_nxt.sz = gb_r.sz;
    dc_nxt.a = gb_r.a;
    for (int l = 0; l < LANES; l++) begin
      mag = MW'(lo_r[l]) + (MW'(hi_r[l]) << NL);
      // rounding to nearest, ties away: floor((2m + a) / 2a)
      dvd = (DVW'(mag) << 1) + DVW'(gb_r.a);
      dc_nxt.lane[l].neg = negb_r[l];
      dc_nxt.lane[l].rem = DRW'(dvd[DVW-1:QTW]);
      dc_nxt.lane[l].low = dvd[QTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end

    ga_r <= in_geo;
    n1_r <= NMW'(NW'(in_geo.p) + NW'(s_eff));
    n2neg_r <= n2_nxt[NW-1];
    n2_r <= n2_nxt[NW-1] ? NMW'(-n2_nxt) : NMW'(n2_nxt);

    gb_r <= ga_r;
    for (int l = 0; l < LANES; l++) begin
      logic [NMW-1:0] nm;
      logic [DW-1:0]  dm;
      logic           dneg;
      nm = (l < 3) ? n1_r : n2_r;
      dneg = dsel[l % 3][DW-1];
      dm = dneg ? DW'(-dsel[l % 3]) : DW'(dsel[l % 3]);
      lo_r[l] <= nm[NL-1:0] * dm;
      hi_r[l] <= nm[NMW-1:NL] * dm;
      negb_r[l] <= dneg ^ ((l >= 3) && n2neg_r);
    end

    dc_r <= dc_nxt;
  end

  // restoring division by 2a, one quotient bit per stage on every lane
  for (genvar j = 0; j < QTW; j++) begin : g_div
    logic         vi;
    ssi_pkg::dv_t di, dn;
    if (j == 0) begin : g_first
      assign vi = vc_r;
      assign di = dc_r;
    end else begin : g_next
      assign vi = vd_r[j-1];
      assign di = dd_r[j-1];
    end

    always_comb begin
      logic [DRW:0] cur, dvs;
      logic         ge;
      dn = di;
      dvs = {1'b0, di.a, 1'b0};
      for (int l = 0; l < LANES; l++) begin
        cur = {di.lane[l].rem, di.lane[l].low[QTW-1]};
        ge = (cur >= dvs);
        dn.lane[l].rem = ge ? DRW'(cur - dvs) : DRW'(cur);
        dn.lane[l].low = {di.lane[l].low[QTW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j] <= 1'b0;
      end else begin
        vd_r[j] <= vi;
      end
      dd_r[j] <= dn;
    end
  end

  // sign, offset from the start point, clamp
  always_comb begin
    logic signed [VW-1:0] qs, base, v;
    ssi_pkg::dv_t         df;
    df = dd_r[QTW-1];
    for (int l = 0; l < LANES; l++) begin
      qs = df.lane[l].neg ? -$signed(VW'(df.lane[l].low)) : $signed(VW'(df.lane[l].low));
      unique case (l % 3)
        0: base = VW'(df.sx);
        1: base = VW'(df.sy);
        default: base = VW'(df.sz);
      endcase
      v = qs + base;
      if (v > VMAX) begin
        coord[l] = CW'(VMAX);
      end else if (v < VMIN) begin
        coord[l] = CW'(VMIN);
      end else begin
        coord[l] = CW'(v);
      end
    end

    out_nxt = '0;
    out_nxt.status = df.status;
    if (df.status == ssi_pkg::ST_TANGENT || df.status == ssi_pkg::ST_TWO) begin
      out_nxt.first_x = coord[0];
      out_nxt.first_y = coord[1];
      out_nxt.first_z = coord[2];
    end
    if (df.status == ssi_pkg::ST_TWO) begin
      out_nxt.second_x = coord[3];
      out_nxt.second_y = coord[4];
      out_nxt.second_z = coord[5];
      out_nxt.hit_count = 2'd2;
    end else if (df.status == ssi_pkg::ST_TANGENT) begin
      out_nxt.hit_count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r[QTW-1];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== hdl/segment_sphere_intersection.sv =====
// channel   direction  handshake           payload
// request   in         start / busy        in_data  (ssi_pkg::in_t)
// result    out        out_valid strobe    out_data (ssi_pkg::out_t)
// config    in         cfg_we              cfg_data (tolerance)
//
// one request per cycle
// pipeline: 7 front stages, 64 square-root stages, 36 divider stages plus 4
// busy is high only while rst_n is low; synchronous reset clears all valid bits
// tolerance resets to 4295; results are strobed and cannot be held off
`default_nettype none
module segment_sphere_intersection (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ssi_pkg::in_t                in_data,
  output logic                        out_valid,
  output ssi_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [ssi_pkg::TOLW-1:0]    cfg_data
);

  logic [ssi_pkg::TOLW-1:0] tol_r;
  logic                     geo_valid, sq_valid;
  ssi_pkg::geo_t            geo, sq_geo;
  logic [ssi_pkg::SQW-1:0]  geo_q;
  logic [ssi_pkg::RTW-1:0]  sq_root;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ssi_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  ssi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .tol       (tol_r),
    .geo_valid (geo_valid),
    .geo       (geo),
    .geo_q     (geo_q)
  );

  ssi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geo_valid),
    .in_geo    (geo),
    .in_q      (geo_q),
    .out_valid (sq_valid),
    .out_geo   (sq_geo),
    .out_root  (sq_root)
  );

  ssi_coord u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_geo    (sq_geo),
    .in_root   (sq_root),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/ssi_checker.sv =====
`default_nettype none
module ssi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input ssi_pkg::out_t out_data
);

  logic no_hit;
  assign no_hit = (out_data.status == ssi_pkg::ST_DEGEN)
               || (out_data.status == ssi_pkg::ST_OFF)
               || (out_data.status == ssi_pkg::ST_MISS);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (no_hit || out_data.status == ssi_pkg::ST_TANGENT
                   || out_data.status == ssi_pkg::ST_TWO))
    else $error("status code out of range");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && no_hit) |-> (out_data.hit_count == 2'd0 && out_data.first_x == '0
      && out_data.first_y == '0 && out_data.first_z == '0 && out_data.second_x == '0
      && out_data.second_y == '0 && out_data.second_z == '0))
    else $error("miss result carries points");

  a_tangent_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ssi_pkg::ST_TANGENT) |->
      (out_data.hit_count == 2'd1 && out_data.second_x == '0
       && out_data.second_y == '0 && out_data.second_z == '0))
    else $error("tangent result malformed");

  a_two_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ssi_pkg::ST_TWO) |-> (out_data.hit_count == 2'd2))
    else $error("two point result has wrong count");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ssi_pkg::LATENCY))
    else $error("result without matching request");

endmodule

bind segment_sphere_intersection ssi_checker u_ssi_checker (.*);
`default_nettype wire
